// ===== hdl/tcp_pkg.sv =====
// Shared types and constants for the transmit-completion token parser.
// Used by the lane, merge, output buffer and top-level modules; no dependencies.

package tcp_pkg;

    // Field widths fixed by the event word layout.
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned TOKEN_W  = 15;
    localparam int unsigned TOTAL_W  = 10;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned VER_W    = 4;

    // Two token slots per body word; one word yields up to three results.
    localparam int unsigned LANES       = 2;
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned SLOT_IDX_W  = 2;

    // Token slot value that means "no token here".
    localparam logic [TOKEN_W-1:0] NO_TOKEN = 15'h7fff;

    // Smallest accepted event version.
    localparam logic [VER_W-1:0] MIN_VERSION = 4'd4;

    // Bit positions within the event words.
    localparam int unsigned PAIR_BIT    = 31;
    localparam int unsigned HEADER_BIT  = 30;
    localparam int unsigned STATUS_LSB  = 28;
    localparam int unsigned TOTAL_LSB   = 16;
    localparam int unsigned VERSION_LSB = 16;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_TOKEN = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Position of the next word within an event, one-hot.
    typedef enum logic [2:0] {
        POS_TOTAL   = 3'b001,
        POS_VERSION = 3'b010,
        POS_BODY    = 3'b100
    } pos_t;

    // Parser state carried from word to word.
    typedef struct packed {
        pos_t                pos;
        logic [TOTAL_W-1:0]  total;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic                finished;
    } state_t;

    // What one token lane found.
    typedef struct packed {
        logic               valid;
        logic [TOKEN_W-1:0] token;
        logic [COUNT_W-1:0] count;
    } lane_t;

    // One result, without its run marker.
    typedef struct packed {
        kind_t               kind;
        logic [TOKEN_W-1:0]  token;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } result_t;

    // Results of one word, compacted into the low slots, with their number.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] slot;
        logic [SLOT_IDX_W-1:0]     num;
    } batch_t;

endpackage

// ===== hdl/tx_completion_token_parser.sv =====
// Top level of the transmit-completion token parser: stream ports, parser state
// and the merge and output-buffer stages. Depends on tcp_pkg, tcp_merge, tcp_outbuf.
//
//  Channel  | Direction | tdata                                       | tuser       | tlast
//  s_axis   | in        | event_word[31:0]                            | -           | final_word
//  m_axis   | out       | released_token, release_status, tokens_rel. | result_kind | run_end
//
// A word is decoded in the cycle it is taken; its zero to three results are
// registered and leave one beat per cycle while m_axis_tready is high.
// The single output channel thus sets how fast words are taken.
// A new word is taken in the cycle the last beat of the previous word leaves.
// Reset (rst_n low) returns the parser to the start of an event and empties the
// output buffer.

module tx_completion_token_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // event_word[31:0]
    input  logic        s_axis_tlast,   // final_word

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // released_token[14:0], release_status[16:15],
                                        // tokens_released[27:17], zero[31:28]
    output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
    output logic        m_axis_tlast    // run_end
);

    tcp_pkg::state_t  state_reg;
    tcp_pkg::state_t  state_next;
    tcp_pkg::state_t  merged_state;
    tcp_pkg::batch_t  batch;
    tcp_pkg::result_t out_result;
    logic             buf_free;
    logic             accept;

    // Input handshake.
    assign s_axis_tready = buf_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode the word and merge the lane results.
    tcp_merge u_merge
    (
        .word       (s_axis_tdata),
        .last       (s_axis_tlast),
        .state      (state_reg),
        .state_next (merged_state),
        .batch      (batch)
    );

    assign state_next = accept ? merged_state : state_reg;

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pos      <= tcp_pkg::POS_TOTAL;
            state_reg.total    <= '0;
            state_reg.count    <= '0;
            state_reg.status   <= '0;
            state_reg.finished <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output buffer.
    tcp_outbuf u_outbuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .batch      (batch),
        .free       (buf_free),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result),
        .out_last   (m_axis_tlast)
    );

    // Output packing.
    assign m_axis_tdata = {4'b0000, out_result.count, out_result.status, out_result.token};
    assign m_axis_tuser = out_result.kind;

    // Assertions.
    a_finished_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.finished |-> (state_reg.pos == tcp_pkg::POS_BODY))
        else $error("event finished outside the body words");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count <= ({1'b0, state_reg.total} + tcp_pkg::COUNT_W'(1))
        || (state_reg.pos != tcp_pkg::POS_BODY))
        else $error("released count overran the expected total");

    a_pos_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg.pos))
        else $error("word position lost its one-hot code");

endmodule

// ===== hdl/tcp_lane.sv =====
// One token lane: checks one 15-bit token slot and advances the running count.
// Depends on tcp_pkg.

module tcp_lane
(
    input  logic                        enable,
    input  logic [tcp_pkg::TOKEN_W-1:0] slot,
    input  logic [tcp_pkg::COUNT_W-1:0] base_count,
    output tcp_pkg::lane_t              lane
);

    // A slot releases a token unless it holds the empty marker.
    always_comb
    begin
        lane.valid = enable && (slot != tcp_pkg::NO_TOKEN);
        lane.token = slot;
        lane.count = base_count + tcp_pkg::COUNT_W'(lane.valid);
    end

endmodule

// ===== hdl/tcp_merge.sv =====
// Word decoder and merge stage: runs the two token lanes on a body word and
// combines their findings with the done/error check. Depends on tcp_pkg, tcp_lane.

module tcp_merge
(
    input  logic [tcp_pkg::WORD_W-1:0] word,
    input  logic                       last,
    input  tcp_pkg::state_t            state,
    output tcp_pkg::state_t            state_next,
    output tcp_pkg::batch_t            batch
);

    logic                              token_word;
    tcp_pkg::lane_t [tcp_pkg::LANES-1:0] lanes;
    logic [tcp_pkg::COUNT_W-1:0]       lane_base [tcp_pkg::LANES];
    logic                              fin;
    tcp_pkg::kind_t                    fin_kind;
    tcp_pkg::result_t                  res_tok0;
    tcp_pkg::result_t                  res_tok1;
    tcp_pkg::result_t                  res_fin;

    // A body word that is neither a pair nor a header carries two tokens.
    assign token_word = !state.finished && (state.pos == tcp_pkg::POS_BODY)
                        && !word[tcp_pkg::PAIR_BIT] && !word[tcp_pkg::HEADER_BIT];

    // Token lanes, each counting on from the lane below it.
    genvar gi;
    generate
        for (gi = 0; gi < tcp_pkg::LANES; gi++)
        begin : g_lane
            if (gi == 0)
            begin : g_first
                assign lane_base[gi] = state.count;
            end
            else
            begin : g_next
                assign lane_base[gi] = lanes[gi-1].count;
            end

            tcp_lane u_lane
            (
                .enable     (token_word),
                .slot       (word[tcp_pkg::TOKEN_W*gi +: tcp_pkg::TOKEN_W]),
                .base_count (lane_base[gi]),
                .lane       (lanes[gi])
            );
        end
    endgenerate

    // Next state and the closing result of the event, if any.
    always_comb
    begin
        state_next = state;
        fin        = 1'b0;
        fin_kind   = tcp_pkg::KIND_DONE;

        if (state.finished)
        begin
            // Skip words until the final marker rearms the parser.
            if (last)
            begin
                state_next.pos      = tcp_pkg::POS_TOTAL;
                state_next.finished = 1'b0;
            end
        end
        else
        begin
            unique case (state.pos)
                tcp_pkg::POS_TOTAL:
                begin
                    state_next.total  = word[tcp_pkg::TOTAL_LSB +: tcp_pkg::TOTAL_W];
                    state_next.count  = '0;
                    state_next.status = '0;
                    state_next.pos    = tcp_pkg::POS_VERSION;
                    if (last)
                    begin
                        fin      = 1'b1;
                        fin_kind = tcp_pkg::KIND_ERROR;
                    end
                end
                tcp_pkg::POS_VERSION:
                begin
                    state_next.pos = tcp_pkg::POS_BODY;
                    if (word[tcp_pkg::VERSION_LSB +: tcp_pkg::VER_W] < tcp_pkg::MIN_VERSION)
                    begin
                        fin      = 1'b1;
                        fin_kind = tcp_pkg::KIND_ERROR;
                    end
                    else if (state.count >= {1'b0, state.total})
                    begin
                        fin      = 1'b1;
                        fin_kind = tcp_pkg::KIND_DONE;
                    end
                    else if (last)
                    begin
                        fin      = 1'b1;
                        fin_kind = tcp_pkg::KIND_ERROR;
                    end
                end
                tcp_pkg::POS_BODY:
                begin
                    if (!word[tcp_pkg::PAIR_BIT] && word[tcp_pkg::HEADER_BIT])
                    begin
                        state_next.status = word[tcp_pkg::STATUS_LSB +: tcp_pkg::STATUS_W];
                    end
                    state_next.count = lanes[tcp_pkg::LANES-1].count;
                    if (state_next.count >= {1'b0, state.total})
                    begin
                        fin      = 1'b1;
                        fin_kind = tcp_pkg::KIND_DONE;
                    end
                    else if (last)
                    begin
                        fin      = 1'b1;
                        fin_kind = tcp_pkg::KIND_ERROR;
                    end
                end
                default:
                begin
                    state_next.pos = tcp_pkg::POS_TOTAL;
                end
            endcase

            // An ended event either rearms at once or waits for the final marker.
            if (fin)
            begin
                if (last)
                begin
                    state_next.pos = tcp_pkg::POS_TOTAL;
                end
                else
                begin
                    state_next.finished = 1'b1;
                end
            end
        end
    end

    // Candidate results: one per lane and the closing one.
    always_comb
    begin
        res_tok0.kind   = tcp_pkg::KIND_TOKEN;
        res_tok0.token  = lanes[0].token;
        res_tok0.status = state_next.status;
        res_tok0.count  = lanes[0].count;

        res_tok1.kind   = tcp_pkg::KIND_TOKEN;
        res_tok1.token  = lanes[1].token;
        res_tok1.status = state_next.status;
        res_tok1.count  = lanes[1].count;

        res_fin.kind    = fin_kind;
        res_fin.token   = '0;
        res_fin.status  = state_next.status;
        res_fin.count   = state_next.count;
    end

    // Pack the valid results into the low slots in arrival order.
    always_comb
    begin
        batch.slot[0] = lanes[0].valid ? res_tok0 : (lanes[1].valid ? res_tok1 : res_fin);
        batch.slot[1] = (lanes[0].valid && lanes[1].valid) ? res_tok1 : res_fin;
        batch.slot[2] = res_fin;
        batch.num     = tcp_pkg::SLOT_IDX_W'(lanes[0].valid) + tcp_pkg::SLOT_IDX_W'(lanes[1].valid)
                        + tcp_pkg::SLOT_IDX_W'(fin);
    end

endmodule

// ===== hdl/tcp_outbuf.sv =====
// Output buffer: holds the results of one word and sends them one beat at a time.
// Depends on tcp_pkg.

module tcp_outbuf
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  tcp_pkg::batch_t                 batch,
    output logic                            free,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tcp_pkg::result_t                out_result,
    output logic                            out_last
);

    tcp_pkg::result_t                  slot_reg [tcp_pkg::MAX_RESULTS];
    logic [tcp_pkg::SLOT_IDX_W-1:0]    num_reg;
    logic [tcp_pkg::SLOT_IDX_W-1:0]    num_next;
    logic [tcp_pkg::SLOT_IDX_W-1:0]    idx_reg;
    logic [tcp_pkg::SLOT_IDX_W-1:0]    idx_next;
    logic                              pop;
    logic                              pop_last;

    // Handshake on the output side and room for a new word.
    assign out_valid = (num_reg != '0);
    assign out_last  = (idx_reg == (num_reg - tcp_pkg::SLOT_IDX_W'(1)));
    assign pop       = out_valid && out_ready;
    assign pop_last  = pop && out_last;
    assign free      = !out_valid || pop_last;

    // Current beat, selected by the read index.
    always_comb
    begin
        case (idx_reg)
            2'd0:    out_result = slot_reg[0];
            2'd1:    out_result = slot_reg[1];
            2'd2:    out_result = slot_reg[2];
            default: out_result = slot_reg[0];
        endcase
    end

    // Fill and read-index control.
    always_comb
    begin
        num_next = num_reg;
        idx_next = idx_reg;
        if (pop_last)
        begin
            num_next = '0;
            idx_next = '0;
        end
        else if (pop)
        begin
            idx_next = idx_reg + tcp_pkg::SLOT_IDX_W'(1);
        end
        if (load)
        begin
            num_next = batch.num;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            num_reg <= num_next;
            idx_reg <= idx_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < tcp_pkg::MAX_RESULTS; i++)
            begin
                slot_reg[i] <= batch.slot[i];
            end
        end
    end

    // Assertions.
    a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
        num_reg <= tcp_pkg::SLOT_IDX_W'(tcp_pkg::MAX_RESULTS))
        else $error("result count out of range");

    a_idx_below_num: assert property (@(posedge clk) disable iff (!rst_n)
        (num_reg != '0) |-> (idx_reg < num_reg))
        else $error("read index past the stored results");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (num_reg == '0) |-> (idx_reg == '0))
        else $error("read index not cleared while empty");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("new word loaded over pending results");

endmodule
